// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent assertions of the RLE decoder checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, off while reset is low.
`define LRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on the rising edge, off while reset is low.
`define LRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lrd_pkg.sv -----
// ----------------------------------------------------------------------------
// lrd_pkg
// Types, constants and helpers shared by the RLE pattern decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrd_pkg;

    // Width of the repeat count, row and column registers.
    localparam int COORD_BITS = 16;
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    // Width of the result fields on the output stream.
    localparam int OUT_BITS = 16;

    // Token queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Characters of the RLE format.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Result kinds.
    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_COMMENT,
        PH_SIZE,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DIGIT,
        OP_BLANK,
        OP_LIVE,
        OP_NEWROW,
        OP_END
    } t_op;

    // One classified body byte, as passed from front to back.
    typedef struct packed {
        logic       clr;    // start of a new pattern: clear counters first
        t_op        op;
        logic [3:0] digit;
    } t_token;

    // Saturating add of two coordinates.
    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic [COORD_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COORD_BITS] ? COORD_MAX : sum[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/life_rle_pattern_decoder.sv -----
// ----------------------------------------------------------------------------
// life_rle_pattern_decoder
// Streaming decoder for run-length-encoded Life patterns, one byte per cycle while the token queue has room.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tdata = char_in[7:0]; tuser = start_of_file
// m_axis    out        tdata = row, col_start, run_length; tuser = kind
//
// One text byte is taken per cycle while the token queue has room. A result
// passes through the queue and the output register: the front classifies
// the accepted byte and writes it into the queue, and the back executes it
// from the queue head into its output register once that register is free.
// The front and back parts are joined by a four-entry token queue; a stalled
// output holds the back part, and s_axis_tready drops only when the queue is
// full. The synchronous reset clears phase, counters, queue and output valid.
`default_nettype none

module life_rle_pattern_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] char_in
    input  wire logic         s_axis_tuser,   // [0] start_of_file

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [15:0] row, [31:16] col_start,
                                              // [47:32] run_length
    output logic              m_axis_tuser    // [0] kind (0 run, 1 end)
);

    // Tokens written by the front part and their view at the queue head.
    lrd_pkg::t_token w_push_token;
    lrd_pkg::t_token w_head_token;
    logic            w_push;
    logic            w_full;
    logic            w_head_valid;
    logic            w_pop;

    logic [lrd_pkg::OUT_BITS-1:0] w_row;
    logic [lrd_pkg::OUT_BITS-1:0] w_col;
    logic [lrd_pkg::OUT_BITS-1:0] w_len;

    // The front part tracks header, comment and size lines and the done phase,
    // so that only body tokens and start-of-file marks travel to the back.
    lrd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_sof   (s_axis_tuser),
        .i_full  (w_full),
        .o_token (w_push_token),
        .o_push  (w_push),
        .o_ready (s_axis_tready)
    );

    lrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_token (w_head_token)
    );

    // The back part applies the repeat count to the row and column and owns
    // the output register that holds a result until m_axis takes it.
    lrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_head_valid),
        .i_token     (w_head_token),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_row       (w_row),
        .o_col       (w_col),
        .o_len       (w_len)
    );

    assign m_axis_tdata = {w_len, w_col, w_row};

endmodule

`default_nettype wire

// ----- sv/lrd_front.sv -----
// ----------------------------------------------------------------------------
// lrd_front
// Accepts text bytes, tracks the header/body phase and emits body tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_char,
    input  wire logic            i_sof,
    input  wire logic            i_full,
    output lrd_pkg::t_token      o_token,
    output logic                 o_push,
    output logic                 o_ready
);

    lrd_pkg::t_phase r_phase;
    lrd_pkg::t_phase n_phase;
    lrd_pkg::t_phase w_cur;
    lrd_pkg::t_op    w_body_op;
    logic            w_accept;
    logic            w_use_body;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lrd_pkg::PH_HDR;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Decode of a byte as body text.
    always_comb begin
        if (i_char >= lrd_pkg::CH_ZERO && i_char <= lrd_pkg::CH_NINE) begin
            w_body_op = lrd_pkg::OP_DIGIT;
        end else if (i_char == lrd_pkg::CH_B) begin
            w_body_op = lrd_pkg::OP_BLANK;
        end else if (i_char == lrd_pkg::CH_O) begin
            w_body_op = lrd_pkg::OP_LIVE;
        end else if (i_char == lrd_pkg::CH_DOLLAR) begin
            w_body_op = lrd_pkg::OP_NEWROW;
        end else if (i_char == lrd_pkg::CH_BANG) begin
            w_body_op = lrd_pkg::OP_END;
        end else begin
            w_body_op = lrd_pkg::OP_NOP;
        end
    end

    always_comb begin
        w_cur      = i_sof ? lrd_pkg::PH_HDR : r_phase;
        n_phase    = r_phase;
        w_use_body = 1'b0;
        case (w_cur)
            lrd_pkg::PH_HDR: begin
                if (i_char == lrd_pkg::CH_HASH) begin
                    n_phase = lrd_pkg::PH_COMMENT;
                end else if (i_char == lrd_pkg::CH_X) begin
                    n_phase = lrd_pkg::PH_SIZE;
                end else begin
                    w_use_body = 1'b1;
                    n_phase    = lrd_pkg::PH_BODY;
                end
            end
            lrd_pkg::PH_COMMENT: begin
                n_phase = (i_char == lrd_pkg::CH_LF) ? lrd_pkg::PH_HDR : lrd_pkg::PH_COMMENT;
            end
            lrd_pkg::PH_SIZE: begin
                n_phase = (i_char == lrd_pkg::CH_LF) ? lrd_pkg::PH_BODY : lrd_pkg::PH_SIZE;
            end
            lrd_pkg::PH_BODY: begin
                w_use_body = 1'b1;
                n_phase    = lrd_pkg::PH_BODY;
            end
            default: begin
                n_phase = lrd_pkg::PH_DONE;
            end
        endcase
        if (w_use_body && w_body_op == lrd_pkg::OP_END) begin
            n_phase = lrd_pkg::PH_DONE;
        end
        if (!w_accept) begin
            n_phase = r_phase;
        end

        o_token.clr   = i_sof;
        o_token.op    = w_use_body ? w_body_op : lrd_pkg::OP_NOP;
        o_token.digit = 4'(i_char - lrd_pkg::CH_ZERO);
        // A start of file must reach the back even when the byte itself is skipped.
        o_push = w_accept && (i_sof || (o_token.op != lrd_pkg::OP_NOP));
    end

endmodule

`default_nettype wire

// ----- sv/lrd_queue.sv -----
// ----------------------------------------------------------------------------
// lrd_queue
// Small token FIFO that decouples the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lrd_pkg::t_token i_token,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output lrd_pkg::t_token      o_token
);

    lrd_pkg::t_token                r_mem [lrd_pkg::QUEUE_DEPTH];
    logic [lrd_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [lrd_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [lrd_pkg::QCNT_BITS-1:0] r_count;

    assign o_full  = (r_count == lrd_pkg::QCNT_BITS'(lrd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/lrd_back.sv -----
// ----------------------------------------------------------------------------
// lrd_back
// Executes body tokens: repeat count, row and column, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire lrd_pkg::t_token             i_token,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_kind,
    output logic [lrd_pkg::OUT_BITS-1:0]     o_row,
    output logic [lrd_pkg::OUT_BITS-1:0]     o_col,
    output logic [lrd_pkg::OUT_BITS-1:0]     o_len
);

    lrd_pkg::t_coord r_rc, n_rc;
    lrd_pkg::t_coord r_row, n_row;
    lrd_pkg::t_coord r_col, n_col;
    logic            r_out_valid, n_out_valid;
    logic            r_kind, n_kind;
    lrd_pkg::t_coord r_o_row, n_o_row;
    lrd_pkg::t_coord r_o_col, n_o_col;
    lrd_pkg::t_coord r_o_len, n_o_len;

    lrd_pkg::t_coord                 w_rc;
    lrd_pkg::t_coord                 w_row;
    lrd_pkg::t_coord                 w_col;
    lrd_pkg::t_coord                 w_cnt;
    logic [lrd_pkg::COORD_BITS+3:0]  w_prod;

    // A token is taken whenever the result slot is free or being emptied.
    assign o_pop = i_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        w_rc   = i_token.clr ? '0 : r_rc;
        w_row  = i_token.clr ? '0 : r_row;
        w_col  = i_token.clr ? '0 : r_col;
        w_cnt  = (w_rc == '0) ? lrd_pkg::t_coord'(1) : w_rc;
        w_prod = ({4'b0, w_rc} << 3) + ({4'b0, w_rc} << 1)
               + {{lrd_pkg::COORD_BITS{1'b0}}, i_token.digit};

        n_rc        = r_rc;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_len     = r_o_len;

        if (o_pop) begin
            n_rc  = w_rc;
            n_row = w_row;
            n_col = w_col;
            case (i_token.op)
                lrd_pkg::OP_DIGIT: begin
                    n_rc = (w_prod > {4'b0, lrd_pkg::COORD_MAX}) ? lrd_pkg::COORD_MAX
                                                                 : w_prod[lrd_pkg::COORD_BITS-1:0];
                end
                lrd_pkg::OP_BLANK: begin
                    n_rc  = '0;
                    n_col = lrd_pkg::sat_add(w_col, w_cnt);
                end
                lrd_pkg::OP_LIVE: begin
                    n_rc        = '0;
                    n_col       = lrd_pkg::sat_add(w_col, w_cnt);
                    n_out_valid = 1'b1;
                    n_kind      = lrd_pkg::KIND_RUN;
                    n_o_row     = w_row;
                    n_o_col     = w_col;
                    n_o_len     = w_cnt;
                end
                lrd_pkg::OP_NEWROW: begin
                    n_rc  = '0;
                    n_row = lrd_pkg::sat_add(w_row, w_cnt);
                    n_col = '0;
                end
                lrd_pkg::OP_END: begin
                    n_rc        = '0;
                    n_out_valid = 1'b1;
                    n_kind      = lrd_pkg::KIND_END;
                    n_o_row     = '0;
                    n_o_col     = '0;
                    n_o_len     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc        <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rc        <= n_rc;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_o_row <= n_o_row;
        r_o_col <= n_o_col;
        r_o_len <= n_o_len;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_row       = lrd_pkg::OUT_BITS'(r_o_row);
    assign o_col       = lrd_pkg::OUT_BITS'(r_o_col);
    assign o_len       = lrd_pkg::OUT_BITS'(r_o_len);

endmodule

`default_nettype wire

// ----- sv/lrd_checker.sv -----
// ----------------------------------------------------------------------------
// lrd_checker
// Port-level checks on the result stream of the RLE pattern decoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // A stalled result must stay put until it is taken.
    `LRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // End results carry no coordinates or length.
    `LRD_ASSERT_SAME(a_end_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 48'd0, "end result with nonzero payload")

    // A run always holds at least one live cell.
    `LRD_ASSERT_SAME(a_run_len, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[47:32] != 16'd0, "live run of zero length")

endmodule

bind life_rle_pattern_decoder lrd_checker u_lrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- bench/tb_life_rle_pattern_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_life_rle_pattern_decoder
// Self-checking bench for the streaming RLE Life pattern decoder.
// ----------------------------------------------------------------------------
//
// Pattern text is queued up front by the stimulus block. A short directed
// section comes first, followed by about a thousand random bytes. Most of the
// random text is well-formed patterns with random header lines, counts,
// whitespace and noise. The rest is loose noise with random start-of-file
// marks.
//
// A clocked driver presents one text request at a time on s_axis. At each
// accepted request, a local model of the decoder predicts the run or end
// result, if any, and queues it. A clocked monitor compares every accepted
// m_axis result field by field with the oldest queued expectation.
//
// Both sides idle in random bursts, except in calm stretches and in the tail
// of the run. A watchdog ends the run if nothing moves for too long.
//
`default_nettype none

module tb_life_rle_pattern_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // Random text bytes queued after the directed section.
    localparam int RANDOM_ITEMS   = 1000;
    // Spacing, in queued requests, of the points where the sender drains.
    localparam int DRAIN_SPACING  = 300;
    // No idling on either side once this few requests are left.
    localparam int QUIET_TAIL     = 150;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 500;
    // Settling time after the last expected result, well above the latency.
    localparam int DRAIN_CYCLES   = 20;
    // Mismatches printed in full; later ones are only counted.
    localparam int REPORT_LIMIT   = 10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // One text byte waiting to be sent. When drain is set, the sender holds
    // this request back until every outstanding result has arrived.
    typedef struct {
        logic [7:0] ch;
        logic       sof;
        bit         drain;
    } t_text_req;

    // One decoded result, with the same fields as the output stream.
    typedef struct packed {
        logic                        kind;
        logic [lrd_pkg::OUT_BITS-1:0] row;
        logic [lrd_pkg::OUT_BITS-1:0] col;
        logic [lrd_pkg::OUT_BITS-1:0] len;
    } t_run_rec;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] char_in
    logic        s_axis_tuser  = 1'b0;  // [0] start_of_file

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [15:0] row, [31:16] col_start,
                                        // [47:32] run_length
    logic        m_axis_tuser;          // [0] kind

    life_rle_pattern_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_text_req pending_text[$];
    t_run_rec  expected_runs[$];

    int  n_faults     = 0;
    int  idle_cycles  = 0;
    bit  wd_expired;

    // Stimulus builder state.
    bit  next_is_first = 1'b0;
    bit  drain_next    = 1'b0;

    // Decoder model state, mirrored from the block.
    lrd_pkg::t_phase dec_phase = lrd_pkg::PH_HDR;
    lrd_pkg::t_coord dec_count = '0;
    lrd_pkg::t_coord dec_row   = '0;
    lrd_pkg::t_coord dec_col   = '0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Coordinates and counts clamp at the top of their range.
    function automatic lrd_pkg::t_coord clamp_add(input lrd_pkg::t_coord a,
                                                  input longint b);
        longint s;
        s = longint'(a) + b;
        return (s > longint'(lrd_pkg::COORD_MAX)) ? lrd_pkg::COORD_MAX
                                                   : lrd_pkg::t_coord'(s);
    endfunction

    // A missing or zero count means one, and every command consumes it.
    function automatic longint consume_count();
        longint n;
        n = (dec_count == '0) ? 1 : longint'(dec_count);
        dec_count = '0;
        return n;
    endfunction

    // Advances the model by one accepted text byte. Returns 1 when the byte
    // produces a result, which is then written to res.
    function automatic bit predict_byte(input logic [7:0] c, input logic sof,
                                        output t_run_rec res);
        longint n;
        longint v;
        res = '0;
        if (sof) begin
            dec_phase = lrd_pkg::PH_HDR;
            dec_count = '0;
            dec_row   = '0;
            dec_col   = '0;
        end
        case (dec_phase)
            lrd_pkg::PH_HDR: begin
                if (c == lrd_pkg::CH_HASH) begin
                    dec_phase = lrd_pkg::PH_COMMENT;
                    return 1'b0;
                end
                if (c == lrd_pkg::CH_X) begin
                    dec_phase = lrd_pkg::PH_SIZE;
                    return 1'b0;
                end
                // Anything else opens the body and is decoded right away.
                dec_phase = lrd_pkg::PH_BODY;
            end
            lrd_pkg::PH_COMMENT: begin
                if (c == lrd_pkg::CH_LF) dec_phase = lrd_pkg::PH_HDR;
                return 1'b0;
            end
            lrd_pkg::PH_SIZE: begin
                if (c == lrd_pkg::CH_LF) dec_phase = lrd_pkg::PH_BODY;
                return 1'b0;
            end
            lrd_pkg::PH_BODY: ;
            default: return 1'b0;
        endcase

        if (c >= lrd_pkg::CH_ZERO && c <= lrd_pkg::CH_NINE) begin
            v = longint'(dec_count) * 10 + (longint'(c) - longint'(lrd_pkg::CH_ZERO));
            dec_count = (v > longint'(lrd_pkg::COORD_MAX)) ? lrd_pkg::COORD_MAX
                                                           : lrd_pkg::t_coord'(v);
            return 1'b0;
        end
        case (c)
            lrd_pkg::CH_B: begin
                dec_col = clamp_add(dec_col, consume_count());
                return 1'b0;
            end
            lrd_pkg::CH_O: begin
                n = consume_count();
                res.kind = lrd_pkg::KIND_RUN;
                res.row  = dec_row[lrd_pkg::OUT_BITS-1:0];
                res.col  = dec_col[lrd_pkg::OUT_BITS-1:0];
                res.len  = n[lrd_pkg::OUT_BITS-1:0];
                dec_col  = clamp_add(dec_col, n);
                return 1'b1;
            end
            lrd_pkg::CH_DOLLAR: begin
                dec_row = clamp_add(dec_row, consume_count());
                dec_col = '0;
                return 1'b0;
            end
            lrd_pkg::CH_BANG: begin
                res.kind  = lrd_pkg::KIND_END;
                dec_count = '0;
                dec_phase = lrd_pkg::PH_DONE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] c);
        t_text_req r;
        r.ch    = c;
        r.sof   = next_is_first;
        r.drain = drain_next;
        next_is_first = 1'b0;
        drain_next    = 1'b0;
        pending_text.push_back(r);
    endtask

    // Writes an optional decimal count (none when n is negative), then op.
    task automatic put_counted(input longint n, input logic [7:0] op);
        string digits;
        if (n >= 0) begin
            digits = $sformatf("%0d", n);
            foreach (digits[i]) put_byte(8'(digits[i]));
        end
        put_byte(op);
    endtask

    // Counts are mostly absent or small. A few are large enough to saturate.
    function automatic longint pick_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return -1;
            4, 5, 6, 7: return longint'($urandom_range(0, 20));
            8:          return longint'($urandom_range(0, 65535));
            default:    return longint'($urandom_range(65536, 999999));
        endcase
    endfunction

    // One well-formed pattern with random content. Now and then the end
    // mark is left out, or junk follows it.
    task automatic put_pattern();
        next_is_first = 1'b1;
        repeat ($urandom_range(0, 2)) begin
            put_byte(lrd_pkg::CH_HASH);
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(32, 126)));
            put_byte(lrd_pkg::CH_LF);
        end
        if ($urandom_range(0, 1) == 1) begin
            put_byte(lrd_pkg::CH_X);
            repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(32, 126)));
            put_byte(lrd_pkg::CH_LF);
        end
        repeat ($urandom_range(2, 20)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_counted(pick_count(), lrd_pkg::CH_O);
                4, 5:       put_counted(pick_count(), lrd_pkg::CH_B);
                6:          put_counted(pick_count(), lrd_pkg::CH_DOLLAR);
                7: begin
                    case ($urandom_range(0, 2))
                        0:       put_byte(CH_SPACE);
                        1:       put_byte(CH_TAB);
                        default: put_byte(lrd_pkg::CH_LF);
                    endcase
                end
                8:       put_byte(8'($urandom_range(0, 255)));
                default: put_counted(pick_count(), lrd_pkg::CH_O);
            endcase
        end
        if ($urandom_range(0, 9) != 0) begin
            put_counted(pick_count(), lrd_pkg::CH_BANG);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Loose bytes with start-of-file raised at random.
    task automatic put_noise();
        repeat ($urandom_range(1, 12)) begin
            next_is_first = ($urandom_range(0, 3) == 0);
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Idling happens in bands of about 128 requests, with a calm band in
    // every three and none at all near the end of the run.
    function automatic bit bursts_allowed();
        int left;
        left = pending_text.size();
        return (left >= QUIET_TAIL) && (((left / 128) % 3) != 2);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents the queued text requests on s_axis.
    // ------------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_text_req req;
        t_run_rec  rec;
        bit        fire;
        bit        next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire && predict_byte(s_axis_tdata, s_axis_tuser, rec)) begin
                expected_runs.push_back(rec);
            end
            // A presented request stays on the bus until it is taken.
            if (!s_axis_tvalid || fire) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_text.size() == 0) begin
                    next_valid = 1'b0;
                end else if (pending_text[0].drain && expected_runs.size() != 0) begin
                    // Hold the sender until the output side has caught up.
                    next_valid = 1'b0;
                end else if (bursts_allowed() && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 8) - 1;
                end else begin
                    req = pending_text.pop_front();
                    s_axis_tdata <= req.ch;
                    s_axis_tuser <= req.sof;
                    next_valid   = 1'b1;
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation.
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_run_rec got;
        t_run_rec want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.row  = m_axis_tdata[15:0];
                got.col  = m_axis_tdata[31:16];
                got.len  = m_axis_tdata[47:32];
                if (expected_runs.size() == 0) begin
                    if (n_faults < REPORT_LIMIT) begin
                        $display("%0t: unexpected result kind=%0d row=%0d col=%0d len=%0d",
                                 $realtime, got.kind, got.row, got.col, got.len);
                    end
                    n_faults++;
                end else begin
                    want = expected_runs.pop_front();
                    if (got.kind !== want.kind || got.row !== want.row ||
                        got.col !== want.col || got.len !== want.len) begin
                        if (n_faults < REPORT_LIMIT) begin
                            $display("%0t: mismatch, expected kind=%0d row=%0d col=%0d len=%0d",
                                     $realtime, want.kind, want.row, want.col, want.len);
                            $display("%0t:           actual   kind=%0d row=%0d col=%0d len=%0d",
                                     $realtime, got.kind, got.row, got.col, got.len);
                        end
                        n_faults++;
                    end
                end
            end
            // The ready line drops in random bursts, except in calm bands and near the end.
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (bursts_allowed() && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither side completes a request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    assign wd_expired = (idle_cycles >= WATCHDOG_LIMIT);

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int next_drain_at;
        int n_directed;

        // Pattern with one comment line, a size line and every command,
        // followed by a byte after the end mark that must be ignored.
        next_is_first = 1'b1;
        put_byte(lrd_pkg::CH_HASH);
        put_byte(lrd_pkg::CH_LF);
        put_byte(lrd_pkg::CH_X);
        put_byte(lrd_pkg::CH_LF);
        put_counted(3, lrd_pkg::CH_O);
        put_byte(lrd_pkg::CH_B);
        put_counted(2, lrd_pkg::CH_DOLLAR);
        put_byte(lrd_pkg::CH_O);
        put_byte(CH_SPACE);
        put_byte(lrd_pkg::CH_BANG);
        put_byte(lrd_pkg::CH_O);

        // Pattern that opens straight into the body with an unknown byte,
        // uses a zero count, saturates the count, the row and the column,
        // shows that '#' is plain noise in the body, and has no end mark.
        next_is_first = 1'b1;
        put_byte(8'hFF);
        put_counted(0, lrd_pkg::CH_O);
        put_counted(99999, lrd_pkg::CH_DOLLAR);
        put_counted(99999, lrd_pkg::CH_O);
        put_byte(lrd_pkg::CH_O);
        put_byte(CH_TAB);
        put_byte(lrd_pkg::CH_HASH);
        n_directed = pending_text.size();

        // Random part. The first random request waits until all results of
        // the directed section are in, and so do a few more along the way.
        drain_next    = 1'b1;
        next_drain_at = n_directed + DRAIN_SPACING;
        while (pending_text.size() < n_directed + RANDOM_ITEMS) begin
            if (pending_text.size() >= next_drain_at) begin
                drain_next    = 1'b1;
                next_drain_at += DRAIN_SPACING;
            end
            if ($urandom_range(0, 9) == 0) put_noise();
            else                            put_pattern();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge, where every driven value is settled.
        while (!wd_expired && !(pending_text.size() == 0 && !s_axis_tvalid &&
                                expected_runs.size() == 0)) begin
            @(negedge i_clk);
        end
        if (!wd_expired) repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (!wd_expired && n_faults == 0 && expected_runs.size() == 0) begin
            $display("tb_life_rle_pattern_decoder: PASS");
        end else begin
            $display("tb_life_rle_pattern_decoder: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/lrd_pkg.sv
sv/lrd_front.sv
sv/lrd_queue.sv
sv/lrd_back.sv
sv/life_rle_pattern_decoder.sv
sv/lrd_checker.sv
bench/tb_life_rle_pattern_decoder.sv
